/* src/command_history_ring_store_unit_assert.svh */
// Assertion macros shared by the command history ring store modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef COMMAND_HISTORY_RING_STORE_UNIT_ASSERT_SVH
`define COMMAND_HISTORY_RING_STORE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/chrs_pkg.sv */
// Package for the command history ring store: opcodes, limits and the
// command and status structs between controller and datapath. No dependencies.
package chrs_pkg;

  localparam int STORE_BYTES_DEF = 64;
  localparam int STAGE_DEPTH     = 64;
  localparam int STAGE_AW        = $clog2(STAGE_DEPTH);
  localparam int CNT_LIMIT       = 32;

  localparam logic [2:0] OP_SAVE  = 3'd0;
  localparam logic [2:0] OP_PREV  = 3'd1;
  localparam logic [2:0] OP_NEXT  = 3'd2;
  localparam logic [2:0] OP_COUNT = 3'd3;
  localparam logic [2:0] OP_GET   = 3'd4;
  localparam logic [2:0] OP_FLUSH = 3'd5;

  typedef enum logic [2:0] {
    EM_NONE = 3'd0,
    EM_ZERO = 3'd1,
    EM_LEN  = 3'd2,
    EM_CNT  = 3'd3,
    EM_CHAR = 3'd4
  } emit_t;

  typedef struct packed {
    logic  accept;
    logic  pos_ld_bp;
    logic  pos_ld_wh;
    logic  wb_init;
    logic  wf_init;
    logic  t_down;
    logic  t_up;
    logic  guard_inc;
    logic  len_inc;
    logic  len_clr;
    logic  back_ok;
    logic  fwd_ok;
    logic  nav_fin;
    logic  dl_init;
    logic  i_inc;
    logic  cm_init;
    logic  same_clr;
    logic  cp_init;
    logic  bp_ld_wh;
    logic  ns_ld_wh;
    logic  hist_wr;
    logic  wr_zero;
    logic  cnt_clr;
    logic  cnt_inc;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       byte_nz;
    logic       t_eq_wh;
    logic       guard_full;
    logic       len_full;
    logic       len_nz;
    logic       deliver_ok;
    logic       osz_zero;
    logic       marks_zero;
    logic       pos_eq_wh;
    logic       turn;
    logic       cnt_at_idx;
    logic       cnt_is_max;
    logic       i_at_last;
    logic       i_eq_len;
    logic       byte_match;
    logic       same;
    logic       commit_ok;
  } st_t;

endpackage

/* src/chrs_datapath.sv */
// Datapath of the command history ring store: byte store, staging memory,
// marks, walk counters and result registers. Depends on chrs_pkg.
`include "command_history_ring_store_unit_assert.svh"
module chrs_datapath #(
  parameter int STORE_BYTES = chrs_pkg::STORE_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  chrs_pkg::cmd_t cmd,
  output chrs_pkg::st_t  st,
  input  logic [2:0]    in_op,
  input  logic [7:0]    in_char_in,
  input  logic          in_char_last,
  input  logic [6:0]    in_out_size,
  input  logic [4:0]    in_cmd_index,
  output logic          out_valid,
  output logic [7:0]    out_char_out,
  output logic          out_run_last,
  output logic [5:0]    out_text_length,
  output logic          out_delivered,
  output logic [5:0]    out_entry_count
);
  import chrs_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [AW-1:0] LAST_POS = AW'(STORE_BYTES - 1);
  localparam logic [6:0] SB7 = 7'(STORE_BYTES);
  localparam logic [6:0] STAGE_FULL = 7'(STAGE_DEPTH);

  logic [7:0] hist_mem [STORE_BYTES];
  logic [7:0] stage_mem [STAGE_DEPTH];
  logic [STORE_BYTES-1:0] valid_r;

  logic [2:0]    op_r;
  logic [6:0]    osz_r;
  logic [4:0]    idx_r;
  logic [AW-1:0] wh_r, bp_r, ns_r, pos_r, start_r, t_r;
  logic          last_dir_r, end_r, same_r;
  logic [6:0]    sl_r, sl_nxt, len_r, guard_r, i_r;
  logic [5:0]    cnt_r;
  logic [7:0]    hrd_r, srd_r;
  logic          hv_r;
  logic [7:0]    hbyte;
  logic          deliver_ok;
  logic          out_valid_r, out_run_last_r, out_delivered_r;
  logic [7:0]    out_char_r;
  logic [5:0]    out_len_r, out_cnt_r;

  function automatic logic [AW-1:0] step_up(input logic [AW-1:0] p);
    return (p == LAST_POS) ? '0 : AW'(p + AW'(1));
  endfunction

  function automatic logic [AW-1:0] step_down(input logic [AW-1:0] p);
    return (p == '0) ? LAST_POS : AW'(p - AW'(1));
  endfunction

  assign hbyte  = hv_r ? hrd_r : 8'h00;
  assign sl_nxt = (sl_r < STAGE_FULL) ? 7'(sl_r + 7'd1) : STAGE_FULL;
  assign deliver_ok = (len_r != '0) && ((8'({1'b0, len_r}) + 8'd1) < {1'b0, osz_r});

  always_comb begin
    st.op         = op_r;
    st.byte_nz    = (hbyte != 8'h00);
    st.t_eq_wh    = (t_r == wh_r);
    st.guard_full = (guard_r >= SB7);
    st.len_full   = (len_r >= SB7);
    st.len_nz     = (len_r != '0);
    st.deliver_ok = deliver_ok;
    st.osz_zero   = (osz_r == '0);
    st.marks_zero = (wh_r == '0) && (bp_r == '0) && (ns_r == '0);
    st.pos_eq_wh  = (pos_r == wh_r);
    st.turn       = (last_dir_r != (op_r == OP_NEXT)) && !end_r;
    st.cnt_at_idx = (cnt_r[4:0] == idx_r);
    st.cnt_is_max = (cnt_r == 6'(CNT_LIMIT - 1));
    st.i_at_last  = (7'(i_r + 7'd1) == len_r);
    st.i_eq_len   = (i_r == len_r);
    st.byte_match = (hbyte == srd_r);
    st.same       = same_r;
    st.commit_ok  = (len_r != '0) && (len_r < SB7);
  end

  // Marks and valid bits; a flush empties the store by clearing the valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wh_r        <= '0;
      bp_r        <= '0;
      ns_r        <= '0;
      last_dir_r  <= 1'b0;
      end_r       <= 1'b0;
      sl_r        <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.emit != EM_NONE);
      if (cmd.accept) begin
        case (in_op)
          OP_SAVE: begin
            sl_r <= in_char_last ? 7'd0 : sl_nxt;
          end
          OP_FLUSH: begin
            wh_r       <= '0;
            bp_r       <= '0;
            ns_r       <= '0;
            last_dir_r <= 1'b0;
            end_r      <= 1'b0;
            valid_r    <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.bp_ld_wh) bp_r <= wh_r;
      if (cmd.ns_ld_wh) ns_r <= wh_r;
      if (cmd.hist_wr) begin
        valid_r[wh_r] <= 1'b1;
        wh_r          <= step_up(wh_r);
        if (cmd.wr_zero) bp_r <= step_up(wh_r);
      end
      if (cmd.nav_fin) begin
        bp_r       <= pos_r;
        last_dir_r <= (op_r == OP_NEXT);
        end_r      <= !deliver_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_wr) hist_mem[wh_r] <= cmd.wr_zero ? 8'h00 : srd_r;
    hrd_r <= hist_mem[t_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_op == OP_SAVE) && (sl_r < STAGE_FULL)) begin
      stage_mem[sl_r[STAGE_AW-1:0]] <= in_char_in;
    end
    srd_r <= stage_mem[i_r[STAGE_AW-1:0]];
  end

  // Working registers of the walks, the compare and copy loops and delivery.
  always_ff @(posedge clk) begin
    hv_r <= valid_r[t_r];
    if (cmd.accept) begin
      op_r  <= in_op;
      osz_r <= in_out_size;
      idx_r <= in_cmd_index;
      if ((in_op == OP_SAVE) && in_char_last) len_r <= sl_nxt;
    end
    if (cmd.pos_ld_bp) pos_r <= bp_r;
    if (cmd.pos_ld_wh) pos_r <= wh_r;
    if (cmd.wb_init) begin
      t_r     <= step_down(pos_r);
      guard_r <= '0;
      len_r   <= '0;
    end
    if (cmd.wf_init) begin
      t_r     <= pos_r;
      start_r <= pos_r;
      len_r   <= '0;
    end
    if (cmd.t_down)    t_r     <= step_down(t_r);
    if (cmd.t_up)      t_r     <= step_up(t_r);
    if (cmd.guard_inc) guard_r <= 7'(guard_r + 7'd1);
    if (cmd.len_inc)   len_r   <= 7'(len_r + 7'd1);
    if (cmd.len_clr)   len_r   <= '0;
    if (cmd.back_ok) begin
      pos_r   <= step_up(t_r);
      start_r <= step_up(t_r);
    end
    if (cmd.fwd_ok) pos_r <= step_up(t_r);
    if (cmd.dl_init) begin
      t_r <= start_r;
      i_r <= '0;
    end
    if (cmd.cm_init) begin
      t_r    <= ns_r;
      i_r    <= '0;
      same_r <= 1'b1;
    end
    if (cmd.same_clr) same_r <= 1'b0;
    if (cmd.cp_init)  i_r    <= '0;
    if (cmd.i_inc)    i_r    <= 7'(i_r + 7'd1);
    if (cmd.cnt_clr)  cnt_r  <= '0;
    if (cmd.cnt_inc)  cnt_r  <= 6'(cnt_r + 6'd1);
    case (cmd.emit)
      EM_ZERO: begin
        out_char_r <= 8'h00; out_run_last_r <= 1'b1; out_len_r <= '0;
        out_delivered_r <= 1'b0; out_cnt_r <= '0;
      end
      EM_LEN: begin
        out_char_r <= 8'h00; out_run_last_r <= 1'b1; out_len_r <= len_r[5:0];
        out_delivered_r <= 1'b0; out_cnt_r <= '0;
      end
      EM_CNT: begin
        out_char_r <= 8'h00; out_run_last_r <= 1'b1; out_len_r <= '0;
        out_delivered_r <= 1'b0; out_cnt_r <= cnt_r;
      end
      EM_CHAR: begin
        out_char_r <= hbyte; out_run_last_r <= st.i_at_last; out_len_r <= len_r[5:0];
        out_delivered_r <= 1'b1; out_cnt_r <= '0;
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_char_out    = out_char_r;
  assign out_run_last    = out_run_last_r;
  assign out_text_length = out_len_r;
  assign out_delivered   = out_delivered_r;
  assign out_entry_count = out_cnt_r;

  `CHRS_ASSERT_NEXT(a_flush_marks, cmd.accept && (in_op == OP_FLUSH),
    (wh_r == '0) && (bp_r == '0) && (ns_r == '0), "flush left a mark set")
  `CHRS_ASSERT_NOW(a_text_nonzero, out_valid_r && out_delivered_r,
    out_char_r != 8'h00, "delivered text holds a terminator byte")
  `CHRS_ASSERT_NOW(a_cnt_range, out_valid_r,
    out_cnt_r <= 6'(CNT_LIMIT), "entry count above its limit")

endmodule

/* src/chrs_ctrl.sv */
// Controller of the command history ring store: sequences walks, compare,
// copy and delivery through the datapath. Depends on chrs_pkg.
`include "command_history_ring_store_unit_assert.svh"
module chrs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [2:0]     in_op,
  input  logic           in_char_last,
  input  chrs_pkg::st_t  st,
  output chrs_pkg::cmd_t cmd,
  output logic           busy
);
  import chrs_pkg::*;

  typedef enum logic [19:0] {
    ST_IDLE    = 20'h00001,
    ST_CM_CHK  = 20'h00002,
    ST_CM_A    = 20'h00004,
    ST_CM_B    = 20'h00008,
    ST_CP_A    = 20'h00010,
    ST_CP_B    = 20'h00020,
    ST_OP_NAV  = 20'h00040,
    ST_OP_CNT  = 20'h00080,
    ST_OP_GET  = 20'h00100,
    ST_WSTART  = 20'h00200,
    ST_BZ_A    = 20'h00400,
    ST_BZ_B    = 20'h00800,
    ST_BN_A    = 20'h01000,
    ST_BN_B    = 20'h02000,
    ST_FW_A    = 20'h04000,
    ST_FW_B    = 20'h08000,
    ST_WDONE   = 20'h10000,
    ST_CNT_OUT = 20'h20000,
    ST_DL_A    = 20'h40000,
    ST_DL_B    = 20'h80000
  } state_t;

  state_t state_r, state_nxt;
  logic   second_r, second_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.emit   = EM_NONE;
    state_nxt  = state_r;
    second_nxt = second_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          case (in_op)
            OP_SAVE:  if (in_char_last) state_nxt = ST_CM_CHK;
            OP_PREV:  state_nxt = ST_OP_NAV;
            OP_NEXT:  state_nxt = ST_OP_NAV;
            OP_COUNT: state_nxt = ST_OP_CNT;
            OP_GET:   state_nxt = ST_OP_GET;
            default:  ;
          endcase
        end
      end
      ST_CM_CHK: begin
        if (st.commit_ok) begin
          cmd.cm_init = 1'b1;
          state_nxt   = ST_CM_A;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CM_A: state_nxt = ST_CM_B;
      ST_CM_B: begin
        // After the staged bytes, the stored command must end right there.
        if (st.i_eq_len) begin
          if (st.same && !st.byte_nz) begin
            cmd.bp_ld_wh = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            cmd.ns_ld_wh = 1'b1;
            cmd.cp_init  = 1'b1;
            state_nxt    = ST_CP_A;
          end
        end else begin
          if (!st.byte_match) cmd.same_clr = 1'b1;
          cmd.t_up  = 1'b1;
          cmd.i_inc = 1'b1;
          state_nxt = ST_CM_A;
        end
      end
      ST_CP_A: state_nxt = ST_CP_B;
      ST_CP_B: begin
        cmd.hist_wr = 1'b1;
        if (st.i_eq_len) begin
          cmd.wr_zero = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = ST_CP_A;
        end
      end
      ST_OP_NAV: begin
        if (st.osz_zero || st.marks_zero) begin
          cmd.emit  = EM_ZERO;
          state_nxt = ST_IDLE;
        end else begin
          cmd.pos_ld_bp = 1'b1;
          second_nxt    = st.turn;
          state_nxt     = ST_WSTART;
        end
      end
      ST_OP_CNT: begin
        cmd.pos_ld_wh = 1'b1;
        cmd.cnt_clr   = 1'b1;
        state_nxt     = ST_WSTART;
      end
      ST_OP_GET: begin
        if (st.osz_zero) begin
          cmd.emit  = EM_ZERO;
          state_nxt = ST_IDLE;
        end else begin
          cmd.pos_ld_wh = 1'b1;
          cmd.cnt_clr   = 1'b1;
          state_nxt     = ST_WSTART;
        end
      end
      ST_WSTART: begin
        if (st.op == OP_NEXT) begin
          if (st.pos_eq_wh) begin
            cmd.len_clr = 1'b1;
            state_nxt   = ST_WDONE;
          end else begin
            cmd.wf_init = 1'b1;
            state_nxt   = ST_FW_A;
          end
        end else begin
          cmd.wb_init = 1'b1;
          state_nxt   = ST_BZ_A;
        end
      end
      ST_BZ_A: state_nxt = ST_BZ_B;
      ST_BZ_B: begin
        if (!st.byte_nz) begin
          if (st.t_eq_wh || st.guard_full) begin
            cmd.len_clr = 1'b1;
            state_nxt   = ST_WDONE;
          end else begin
            cmd.t_down    = 1'b1;
            cmd.guard_inc = 1'b1;
            state_nxt     = ST_BZ_A;
          end
        end else begin
          state_nxt = ST_BN_A;
        end
      end
      ST_BN_A: state_nxt = ST_BN_B;
      ST_BN_B: begin
        if (st.byte_nz) begin
          if (st.t_eq_wh || st.len_full) begin
            cmd.len_clr = 1'b1;
            state_nxt   = ST_WDONE;
          end else begin
            cmd.t_down  = 1'b1;
            cmd.len_inc = 1'b1;
            state_nxt   = ST_BN_A;
          end
        end else begin
          cmd.back_ok = 1'b1;
          state_nxt   = ST_WDONE;
        end
      end
      ST_FW_A: state_nxt = ST_FW_B;
      ST_FW_B: begin
        if (st.byte_nz) begin
          if (st.t_eq_wh || st.len_full) begin
            cmd.len_clr = 1'b1;
            state_nxt   = ST_WDONE;
          end else begin
            cmd.t_up    = 1'b1;
            cmd.len_inc = 1'b1;
            state_nxt   = ST_FW_A;
          end
        end else begin
          cmd.fwd_ok = 1'b1;
          state_nxt  = ST_WDONE;
        end
      end
      ST_WDONE: begin
        case (st.op)
          OP_PREV, OP_NEXT: begin
            // A change of direction costs one extra walk in the new direction.
            if (second_r) begin
              second_nxt = 1'b0;
              state_nxt  = ST_WSTART;
            end else begin
              cmd.nav_fin = 1'b1;
              if (st.deliver_ok) begin
                cmd.dl_init = 1'b1;
                state_nxt   = ST_DL_A;
              end else begin
                cmd.emit  = EM_LEN;
                state_nxt = ST_IDLE;
              end
            end
          end
          OP_COUNT: begin
            if (st.len_nz) begin
              cmd.cnt_inc = 1'b1;
              state_nxt   = st.cnt_is_max ? ST_CNT_OUT : ST_WSTART;
            end else begin
              state_nxt = ST_CNT_OUT;
            end
          end
          OP_GET: begin
            if (!st.len_nz) begin
              cmd.emit  = EM_ZERO;
              state_nxt = ST_IDLE;
            end else if (st.cnt_at_idx) begin
              if (st.deliver_ok) begin
                cmd.dl_init = 1'b1;
                state_nxt   = ST_DL_A;
              end else begin
                cmd.emit  = EM_ZERO;
                state_nxt = ST_IDLE;
              end
            end else begin
              cmd.cnt_inc = 1'b1;
              state_nxt   = ST_WSTART;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_CNT_OUT: begin
        cmd.emit  = EM_CNT;
        state_nxt = ST_IDLE;
      end
      ST_DL_A: state_nxt = ST_DL_B;
      ST_DL_B: begin
        cmd.emit  = EM_CHAR;
        cmd.t_up  = 1'b1;
        cmd.i_inc = 1'b1;
        state_nxt = st.i_at_last ? ST_IDLE : ST_DL_A;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `CHRS_ASSERT_NEXT(a_dl_end, (state_r == ST_DL_B) && st.i_at_last,
    state_r == ST_IDLE, "delivery did not end after its last character")
  `CHRS_ASSERT_NEXT(a_flush_idle, (state_r == ST_IDLE) && start && (in_op == OP_FLUSH),
    state_r == ST_IDLE, "flush left the controller busy")
  `CHRS_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_r),
    "controller state is not one-hot")

endmodule

/* src/command_history_ring_store_unit.sv */
// Top level of the command history ring store: controller plus datapath.
// Depends on chrs_pkg, chrs_ctrl and chrs_datapath.
//
//   Channel   Handshake               Ports
//   input     start high, busy low    in_op, in_char_in, in_char_last,
//                                     in_out_size, in_cmd_index
//   result    out_valid strobe        out_char_out, out_run_last,
//                                     out_text_length, out_delivered,
//                                     out_entry_count
//
// A save of a non-final character never raises busy, nor do flush and unknown ops.
// Every byte visited in the store is read through its single read port with
// registered data; a commit compares and then copies the staged bytes,
// previous/next and get walk the store and then deliver the text when it fits,
// and count walks up to 32 commands. Reset is synchronous and empties the store
// at once. Results come as one-cycle strobes; busy drops in the cycle that
// carries the last result of a transaction.
module command_history_ring_store_unit #(
  parameter int STORE_BYTES = chrs_pkg::STORE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_op,
  input  logic [7:0] in_char_in,
  input  logic       in_char_last,
  input  logic [6:0] in_out_size,
  input  logic [4:0] in_cmd_index,
  output logic       out_valid,
  output logic [7:0] out_char_out,
  output logic       out_run_last,
  output logic [5:0] out_text_length,
  output logic       out_delivered,
  output logic [5:0] out_entry_count
);
  import chrs_pkg::*;

  cmd_t cmd;
  st_t  st;

  chrs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_op        (in_op),
    .in_char_last (in_char_last),
    .st           (st),
    .cmd          (cmd),
    .busy         (busy)
  );

  chrs_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_op           (in_op),
    .in_char_in      (in_char_in),
    .in_char_last    (in_char_last),
    .in_out_size     (in_out_size),
    .in_cmd_index    (in_cmd_index),
    .out_valid       (out_valid),
    .out_char_out    (out_char_out),
    .out_run_last    (out_run_last),
    .out_text_length (out_text_length),
    .out_delivered   (out_delivered),
    .out_entry_count (out_entry_count)
  );

endmodule
